// ===== sv/fifo_replacement_key_cache_defines.svh =====
// assertion macros for the key cache
`ifndef FIFO_REPLACEMENT_KEY_CACHE_DEFINES_SVH
`define FIFO_REPLACEMENT_KEY_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

`define FKC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define FKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FKC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)

`define FKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/fkc_pkg.sv =====
// types and constants shared by the key cache modules
`timescale 1ns / 1ps

package fkc_pkg;

  localparam int ENTRIES = 64;
  localparam int KEY_W   = 21;
  localparam int CAP_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CMP_W   = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic ACT_GET   = 1'b0;
  localparam logic ACT_PROBE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic             fill_ok;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== sv/fkc_ctrl.sv =====
// sequencing state machine and handshake control of the key cache
`timescale 1ns / 1ps

module fkc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fkc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       commit, load, in_stall;

  assign commit   = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);
  assign in_stall = !((state_q == ST_IDLE) || commit);
  assign load     = in_valid_i && !in_stall;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (commit) begin
          state_d = load ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = in_stall;
  assign out_valid_o   = out_valid_q;
  assign cmd_o.load    = load;
  assign cmd_o.compare = (state_q == ST_CMP);
  assign cmd_o.commit  = commit;

endmodule

// ===== sv/fkc_datapath.sv =====
// tag store, parallel compare, fill and replacement pointers of the key cache
`timescale 1ns / 1ps

module fkc_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fkc_pkg::ctrl_cmd_t         cmd_i,
  input  fkc_pkg::in_item_t          in_item_i,
  input  logic                       cfg_we_i,
  input  logic [fkc_pkg::CAP_W-1:0]  cfg_data_i,
  output fkc_pkg::out_item_t         out_item_o
);

  fkc_pkg::in_item_t              item_q;
  fkc_pkg::out_item_t             res_q, res_d;
  logic [fkc_pkg::CAP_W-1:0]      cap_q;
  logic [fkc_pkg::CNT_W-1:0]      count_q;
  logic [fkc_pkg::IDX_W-1:0]      ptr_q, ptr_d;
  logic [fkc_pkg::ENTRIES-1:0]    match_q, match_d;
  logic [fkc_pkg::KEY_W-1:0]      store_q [fkc_pkg::ENTRIES];

  logic [fkc_pkg::CMP_W-1:0]      eff_cap, cap_ext, count_ext, ptr_ext, ptr_inc;
  logic                           found, do_fill, has_free;
  logic [fkc_pkg::IDX_W-1:0]      where_idx, fill_idx;

  // compare lanes, one per slot
  always_comb begin
    for (int i = 0; i < fkc_pkg::ENTRIES; i++) begin
      match_d[i] = (fkc_pkg::CNT_W'(i) < count_q) && (store_q[i] == item_q.key);
    end
  end

  // lowest matching slot
  always_comb begin
    where_idx = '0;
    for (int i = fkc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        where_idx = fkc_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    cap_ext   = fkc_pkg::CMP_W'(cap_q);
    count_ext = fkc_pkg::CMP_W'(count_q);
    ptr_ext   = fkc_pkg::CMP_W'(ptr_q);
    priority if (cap_ext == '0) begin
      eff_cap = fkc_pkg::CMP_W'(1);
    end else if (cap_ext > fkc_pkg::CMP_W'(fkc_pkg::ENTRIES)) begin
      eff_cap = fkc_pkg::CMP_W'(fkc_pkg::ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    found    = |match_q;
    do_fill  = !found && (item_q.action == fkc_pkg::ACT_GET) && item_q.fill_ok;
    has_free = count_ext < eff_cap;
    if (has_free) begin
      fill_idx = count_q[fkc_pkg::IDX_W-1:0];
    end else if (ptr_ext >= fkc_pkg::CMP_W'(fkc_pkg::ENTRIES)) begin
      fill_idx = '0;
    end else begin
      fill_idx = ptr_q;
    end
    ptr_inc = fkc_pkg::CMP_W'(fill_idx) + fkc_pkg::CMP_W'(1);
    ptr_d   = (ptr_inc >= eff_cap) ? '0 : ptr_inc[fkc_pkg::IDX_W-1:0];

    res_d.hit        = found;
    res_d.slot_valid = found || do_fill;
    res_d.evicted    = do_fill && !has_free;
    priority if (found) begin
      res_d.slot = fkc_pkg::SLOT_W'(where_idx);
    end else if (do_fill) begin
      res_d.slot = fkc_pkg::SLOT_W'(fill_idx);
    end else begin
      res_d.slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= fkc_pkg::CAP_RESET;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.commit && do_fill) begin
        if (has_free) begin
          count_q <= count_q + fkc_pkg::CNT_W'(1);
        end else begin
          ptr_q <= ptr_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
    if (cmd_i.commit && do_fill) begin
      store_q[fill_idx] <= item_q.key;
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== sv/fifo_replacement_key_cache.sv =====
// fully associative code point cache with fifo replacement: top level
// item register, then match register (compare), then result register (update)
// a new item is accepted only in idle or when the previous item commits
// the update cycle waits while the output register holds an untaken item
// reset clears fill count, replace pointer and output valid; capacity resets to 64
// the key store is not cleared: only slots below the fill count are compared
`timescale 1ns / 1ps
`include "fifo_replacement_key_cache_defines.svh"

module fifo_replacement_key_cache (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fkc_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fkc_pkg::out_item_t        out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fkc_pkg::CAP_W-1:0] cfg_data_i
);

  fkc_pkg::ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  fkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fkc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

  `FKC_ASSERT_NEXT(a_no_accept_in_compare, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted during compare cycle")
  `FKC_ASSERT_SAME(a_evict_is_fill, clk_i, rst_ni, out_valid_o && out_item_o.evicted, out_item_o.slot_valid && !out_item_o.hit, "eviction without a fill")
  `FKC_ASSERT_SAME(a_hit_has_slot, clk_i, rst_ni, out_valid_o && out_item_o.hit, out_item_o.slot_valid && !out_item_o.evicted, "hit without a valid slot")
  `FKC_ASSERT_NEXT(a_commit_shows_result, clk_i, rst_ni, cmd.commit, out_valid_o, "committed item not presented")

endmodule
